// ----- design/rwe_pkg.sv -----
// Shared constants and types for the repeat window encoder.
package rwe_pkg;

  localparam int WIN_BYTES = 32;
  localparam int MAX_MATCH = 8;
  localparam int IDX_W     = $clog2(WIN_BYTES);
  localparam int LEN_W     = $clog2(MAX_MATCH) + 1;
  localparam int FILL_W    = $clog2(WIN_BYTES) + 1;
  localparam int TOKLEN_W  = $clog2(MAX_MATCH);

  localparam logic [7:0] LITERAL_MARK = 8'hFF;

  typedef struct packed {
    logic shift;   // take the neighbour's byte
    logic eq_en;   // latch compare vector against the lookahead
  } rwe_cell_ctl_t;

  typedef struct packed {
    logic len_en;  // latch per-start match lengths
    logic best_en; // latch winner of the tree
  } rwe_pick_ctl_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;  // 0 means no match
    logic [IDX_W-1:0] idx;  // cell index, distance is idx+1
  } rwe_best_t;

endpackage

// ----- design/repeat_window_encoder.sv -----
// Top level: small-window LZ-style encoder, input staging, sequencer and output register.
//
// Raw bytes arrive as beats on the in_ channel (in_data_byte, in_last_in) and coded
// bytes leave as beats on the out_ channel (out_byte, out_last_out). Both channels
// use valid/stall; a beat moves when valid is high and stall is low.
// A byte is taken while the lookahead has room. Once eight bytes are
// pending, or a byte flagged last arrives, a coding decision runs: the EQ step
// latches the compare vectors of the 32 history cells, the LEN step latches the
// per-start lengths, the PICK step latches the winner of the comparison tree. The
// token (or the marker 255 and the literal) is then loaded into the output register,
// one byte per cycle while the output is not stalled, and the consumed bytes walk
// into the history chain, one byte per cycle. A last beat repeats decisions until
// the lookahead is empty and marks the final coded byte with out_last_out.
// in_stall is high whenever a decision is in progress. A stalled output holds its
// beat and the sequencer waits in its emit step. Reset empties the history and the
// lookahead and drops out_valid; a new stream starts after every last beat.
module repeat_window_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_out
);
  import rwe_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EQ    = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_PICK  = 3'd3;
  localparam logic [2:0] ST_EMIT1 = 3'd4;
  localparam logic [2:0] ST_EMIT2 = 3'd5;
  localparam logic [2:0] ST_SHIFT = 3'd6;

  logic [2:0]                      state_r, state_nxt;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic [LEN_W-1:0]                cnt_r, cnt_nxt;
  logic [LEN_W-1:0]                shl_r, shl_nxt;
  logic                            flush_r, flush_nxt;
  logic [MAX_MATCH-1:0][7:0]       la_r, la_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;

  rwe_cell_ctl_t                   cell_ctl;
  rwe_pick_ctl_t                   pick_ctl;
  rwe_best_t                       best;
  logic [WIN_BYTES-1:0][7:0]       cell_byte;
  logic [WIN_BYTES-1:0][MAX_MATCH-1:0] cell_eq;
  logic [WIN_BYTES-1:0][MAX_MATCH-1:0] run;

  logic                            out_free;
  logic                            is_lit;
  logic [LEN_W-1:0]                used;
  logic                            final_dec;
  logic [7:0]                      token;

  // history chain, cell 0 holds the newest byte (distance 1)
  generate
    for (genvar i = 0; i < WIN_BYTES; i++) begin : g_cell
      if (i == 0) begin : g_head
        rwe_cell u_cell (
          .clk     (clk),
          .ctl     (cell_ctl),
          .byte_in (la_r[0]),
          .la      (la_r),
          .byte_q  (cell_byte[i]),
          .eq_q    (cell_eq[i])
        );
      end else begin : g_body
        rwe_cell u_cell (
          .clk     (clk),
          .ctl     (cell_ctl),
          .byte_in (cell_byte[i-1]),
          .la      (la_r),
          .byte_q  (cell_byte[i]),
          .eq_q    (cell_eq[i])
        );
      end
      // a run from start i steps towards the newer cells
      for (genvar j = 0; j < MAX_MATCH; j++) begin : g_run
        if (j <= i) begin : g_in
          assign run[i][j] = cell_eq[i-j][j];
        end else begin : g_out
          assign run[i][j] = 1'b0;
        end
      end
    end
  endgenerate

  rwe_pick u_pick (
    .clk  (clk),
    .ctl  (pick_ctl),
    .run  (run),
    .fill (fill_r),
    .cnt  (cnt_r),
    .best (best)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign is_lit    = (best.len == '0);
  assign used      = is_lit ? LEN_W'(1) : best.len;
  assign final_dec = flush_r && (used == cnt_r);
  assign token     = {~best.idx, TOKLEN_W'(best.len - LEN_W'(1))};

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    shl_nxt       = shl_r;
    flush_nxt     = flush_r;
    la_nxt        = la_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    cell_ctl      = '0;
    pick_ctl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          la_nxt[cnt_r[TOKLEN_W-1:0]] = in_data_byte;
          cnt_nxt = cnt_r + LEN_W'(1);
          if (in_last_in) begin
            flush_nxt = 1'b1;
            state_nxt = ST_EQ;
          end else if (cnt_r == LEN_W'(MAX_MATCH - 1)) begin
            state_nxt = ST_EQ;
          end
        end
      end
      ST_EQ: begin
        cell_ctl.eq_en = 1'b1;
        state_nxt      = ST_LEN;
      end
      ST_LEN: begin
        pick_ctl.len_en = 1'b1;
        state_nxt       = ST_PICK;
      end
      ST_PICK: begin
        pick_ctl.best_en = 1'b1;
        state_nxt        = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = is_lit ? LITERAL_MARK : token;
          out_last_nxt  = !is_lit && final_dec;
          shl_nxt       = used;
          state_nxt     = is_lit ? ST_EMIT2 : ST_SHIFT;
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = la_r[0];
          out_last_nxt  = final_dec;
          state_nxt     = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cell_ctl.shift = 1'b1;
        for (int j = 0; j < MAX_MATCH - 1; j++) begin
          la_nxt[j] = la_r[j+1];
        end
        cnt_nxt = cnt_r - LEN_W'(1);
        shl_nxt = shl_r - LEN_W'(1);
        if (fill_r < FILL_W'(WIN_BYTES)) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        if (shl_r == LEN_W'(1)) begin
          if (!flush_r) begin
            state_nxt = ST_IDLE;
          end else if (cnt_r == LEN_W'(1)) begin
            // stream done: the next byte opens a fresh history
            fill_nxt  = '0;
            flush_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EQ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      shl_r       <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      shl_r       <= shl_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    la_r       <= la_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_last_out = out_last_r;

endmodule

// ----- design/rwe_cell.sv -----
// One history cell: holds a byte, shifts it on, compares it with the lookahead.
module rwe_cell (
  input  logic                                  clk,
  input  rwe_pkg::rwe_cell_ctl_t                ctl,
  input  logic [7:0]                            byte_in,
  input  logic [rwe_pkg::MAX_MATCH-1:0][7:0]    la,
  output logic [7:0]                            byte_q,
  output logic [rwe_pkg::MAX_MATCH-1:0]         eq_q
);
  import rwe_pkg::*;

  logic [7:0]           byte_r;
  logic [MAX_MATCH-1:0] eq_r;
  logic [MAX_MATCH-1:0] eq_nxt;

  always_comb begin
    for (int j = 0; j < MAX_MATCH; j++) begin
      eq_nxt[j] = (byte_r == la[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
    if (ctl.eq_en) begin
      eq_r <= eq_nxt;
    end
  end

  assign byte_q = byte_r;
  assign eq_q   = eq_r;

endmodule

// ----- design/rwe_pick.sv -----
// Match length per start position and a registered longest-match tree.
module rwe_pick (
  input  logic                                                     clk,
  input  rwe_pkg::rwe_pick_ctl_t                                   ctl,
  input  logic [rwe_pkg::WIN_BYTES-1:0][rwe_pkg::MAX_MATCH-1:0]    run,
  input  logic [rwe_pkg::FILL_W-1:0]                               fill,
  input  logic [rwe_pkg::LEN_W-1:0]                                cnt,
  output rwe_pkg::rwe_best_t                                       best
);
  import rwe_pkg::*;

  localparam int LEVELS = IDX_W;

  logic [WIN_BYTES-1:0][LEN_W-1:0] len_nxt;
  logic [WIN_BYTES-1:0][LEN_W-1:0] len_r;
  logic [WIN_BYTES-1:0]            go;
  rwe_best_t                       best_r;

  logic [LEN_W-1:0] lv_len [0:LEVELS][0:WIN_BYTES-1];
  logic [IDX_W-1:0] lv_idx [0:LEVELS][0:WIN_BYTES-1];

  // run[i][j] already holds zero where j passes the distance
  always_comb begin
    for (int i = 0; i < WIN_BYTES; i++) begin
      go[i]      = (FILL_W'(i) < fill);
      len_nxt[i] = '0;
      for (int j = 0; j < MAX_MATCH; j++) begin
        if (go[i] && (LEN_W'(j) < cnt) && run[i][j]) begin
          len_nxt[i] = len_nxt[i] + LEN_W'(1);
        end else begin
          go[i] = 1'b0;
        end
      end
    end
  end

  generate
    for (genvar n = 0; n < WIN_BYTES; n++) begin : g_leaf
      assign lv_len[0][n] = len_r[n];
      assign lv_idx[0][n] = IDX_W'(n);
    end
    // higher index is the older start, so it takes ties
    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
      for (genvar n = 0; n < (WIN_BYTES >> (l + 1)); n++) begin : g_node
        always_comb begin
          if (lv_len[l][2*n+1] >= lv_len[l][2*n]) begin
            lv_len[l+1][n] = lv_len[l][2*n+1];
            lv_idx[l+1][n] = lv_idx[l][2*n+1];
          end else begin
            lv_len[l+1][n] = lv_len[l][2*n];
            lv_idx[l+1][n] = lv_idx[l][2*n];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctl.len_en) begin
      len_r <= len_nxt;
    end
    if (ctl.best_en) begin
      best_r.len <= lv_len[LEVELS][0];
      best_r.idx <= lv_idx[LEVELS][0];
    end
  end

  assign best = best_r;

endmodule
